// ===== rtl/sssw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssw_pkg
// Types, command codes and sequence tables for the two-wire
// seven-segment display writer.
// ----------------------------------------------------------------------------
package sssw_pkg;

  localparam int unsigned DIGIT_COUNT_DEF = 4;
  localparam int unsigned BITS_PER_BYTE   = 8;

  localparam logic [7:0] CTRL_BASE = 8'h88;
  localparam logic [7:0] CMD_AUTO  = 8'h40;
  localparam logic [7:0] CMD_FIXED = 8'h44;
  localparam logic [7:0] CMD_ADDR  = 8'hC0;

  localparam logic [2:0] BRIGHT_RESET = 3'd4;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_ONE  = 2'd1,
    FUNC_ALL  = 2'd2,
    FUNC_INIT = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    EL_START = 2'd0,
    EL_BYTE  = 2'd1,
    EL_STOP  = 2'd2,
    EL_END   = 2'd3
  } elem_kind_t;

  typedef struct packed {
    elem_kind_t kind;
    logic [7:0] value;
  } elem_t;

  typedef logic [3:0][3:0] digit_vec_t;

  typedef struct packed {
    func_t      func;
    logic [2:0] column;
    logic [3:0] digit0;
    logic [3:0] digit1;
    logic [3:0] digit2;
    logic [3:0] digit3;
  } in_item_t;

  typedef struct packed {
    logic clk_pin;
    logic dio_pin;
    logic dio_drive;
    logic busy_res;
    logic rejected;
  } out_item_t;

  // bit 0 = segment a ... bit 6 = segment g
  localparam logic [6:0] SEG_TABLE [16] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
    7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71
  };

  function automatic logic [7:0] seg(input logic [3:0] d);
    return {1'b0, SEG_TABLE[d]};
  endfunction

  // Element of the frame sequence at step s for the latched command.
  function automatic elem_t element_at(input func_t f, input logic [3:0] s,
                                       input logic [2:0] col, input digit_vec_t dg,
                                       input logic [2:0] br, input int unsigned n);
    elem_t      e;
    logic [3:0] t;
    logic [3:0] k;
    e.kind  = EL_END;
    e.value = '0;
    t       = s;
    k       = '0;
    case (f)
      FUNC_ONE: begin
        case (s)
          4'd0: e.kind = EL_START;
          4'd1: begin
            e.kind  = EL_BYTE;
            e.value = CMD_FIXED;
          end
          4'd2: e.kind = EL_STOP;
          4'd3: e.kind = EL_START;
          4'd4: begin
            e.kind  = EL_BYTE;
            e.value = CMD_ADDR | {5'b0, col};
          end
          4'd5: begin
            e.kind  = EL_BYTE;
            e.value = seg(dg[0]);
          end
          4'd6: e.kind = EL_STOP;
          default: e.kind = EL_END;
        endcase
      end
      FUNC_ALL, FUNC_INIT: begin
        if (f == FUNC_INIT && s < 4'd3) begin
          // display control frame ahead of the zero digits
          if (s == 4'd1) begin
            e.kind  = EL_BYTE;
            e.value = CTRL_BASE + {5'b0, br};
          end else if (s == 4'd0) begin
            e.kind = EL_START;
          end else begin
            e.kind = EL_STOP;
          end
        end else begin
          if (f == FUNC_INIT) begin
            t = s - 4'd3;
          end
          k = t - 4'd5;
          if (t == 4'd0 || t == 4'd3) begin
            e.kind = EL_START;
          end else if (t == 4'd1) begin
            e.kind  = EL_BYTE;
            e.value = CMD_AUTO;
          end else if (t == 4'd2) begin
            e.kind = EL_STOP;
          end else if (t == 4'd4) begin
            e.kind  = EL_BYTE;
            e.value = CMD_ADDR;
          end else if (32'(t) < 32'd5 + n) begin
            e.kind  = EL_BYTE;
            e.value = (k < 4'd4) ? seg(dg[k[1:0]]) : seg(4'd0);
          end else if (32'(t) == 32'd5 + n) begin
            e.kind = EL_STOP;
          end else begin
            e.kind = EL_END;
          end
        end
      end
      default: e.kind = EL_END;
    endcase
    return e;
  endfunction

endpackage

// ===== rtl/seven_segment_serial_writer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_serial_writer_unit
// Two-wire write master for a seven-segment display driver.
// ----------------------------------------------------------------------------
// Usage:
//   in_* channel (valid/stall): one beat is a command (write one digit,
//   write all digits, initialise) or a tick. A command latches its
//   operands and starts a frame sequence; each later tick plays one pin
//   phase. A command that arrives while busy is dropped and flagged.
//   out_* channel (valid/stall): exactly one result beat per input beat,
//   carrying the pin levels after that beat, busy and rejected flags.
//   cfg_* channel (valid/ready): brightness, sampled when initialise is
//   accepted. ready is always high.
// Timing: each result is registered directly from its input beat. The
//   whole step is one pass of logic from state to the result register,
//   so one beat per cycle is sustained while out_stall is low. in_stall
//   is high only while a result waits and the receiver stalls it.
// Reset: idle, clock low, data low and driven, brightness 4.
// ----------------------------------------------------------------------------
module seven_segment_serial_writer_unit
  import sssw_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_data
);

  logic       in_accept;
  logic [2:0] brightness;

  logic [1:0] phase, phase_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [3:0] bit_count, bit_count_next;
  logic [3:0] sequence_step, sequence_step_next;
  logic       active, active_next;
  digit_vec_t latched_digits, latched_digits_next;
  logic [2:0] latched_column, latched_column_next;
  func_t      latched_func, latched_func_next;
  logic [2:0] latched_bright, latched_bright_next;
  logic       clk_lvl, clk_lvl_next;
  logic       dio_lvl, dio_lvl_next;
  logic       drive_lvl, drive_lvl_next;

  logic       rej;
  logic       done;
  logic       is_start;
  elem_t      cur_el;
  elem_t      nxt_el;
  out_item_t  result;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= BRIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      brightness <= cfg_data;
    end
  end

  always_comb begin
    phase_next          = phase;
    shift_byte_next     = shift_byte;
    bit_count_next      = bit_count;
    sequence_step_next  = sequence_step;
    active_next         = active;
    latched_digits_next = latched_digits;
    latched_column_next = latched_column;
    latched_func_next   = latched_func;
    latched_bright_next = latched_bright;
    clk_lvl_next        = clk_lvl;
    dio_lvl_next        = dio_lvl;
    drive_lvl_next      = drive_lvl;
    rej                 = 1'b0;
    done                = 1'b0;
    is_start            = 1'b0;

    cur_el = element_at(latched_func, sequence_step, latched_column, latched_digits,
                        latched_bright, DIGIT_COUNT);
    nxt_el = element_at(latched_func, sequence_step + 4'd1, latched_column,
                        latched_digits, latched_bright, DIGIT_COUNT);

    if (in_data.func != FUNC_TICK) begin
      if (active) begin
        rej = 1'b1;
      end else begin
        latched_func_next   = in_data.func;
        latched_column_next = in_data.column;
        if (in_data.func == FUNC_INIT) begin
          latched_digits_next = '0;
        end else begin
          latched_digits_next = {in_data.digit3, in_data.digit2,
                                 in_data.digit1, in_data.digit0};
        end
        latched_bright_next = brightness;
        sequence_step_next  = '0;
        phase_next          = '0;
        bit_count_next      = '0;
        active_next         = 1'b1;
      end
    end else if (active) begin
      case (cur_el.kind)
        EL_START, EL_STOP: begin
          is_start = (cur_el.kind == EL_START);
          case (phase)
            2'd0: clk_lvl_next = is_start;
            2'd1: dio_lvl_next = is_start;
            2'd2: begin
              if (is_start) begin
                dio_lvl_next = 1'b0;
              end else begin
                clk_lvl_next = 1'b1;
              end
            end
            default: begin
              if (is_start) begin
                clk_lvl_next = 1'b0;
              end else begin
                dio_lvl_next = 1'b1;
              end
              done = 1'b1;
            end
          endcase
          phase_next = phase + 2'd1;
        end
        EL_BYTE: begin
          if (32'(bit_count) < BITS_PER_BYTE) begin
            if (phase == 2'd0) begin
              if (bit_count == 4'd0) begin
                shift_byte_next = cur_el.value;
              end
              clk_lvl_next = 1'b0;
              phase_next   = 2'd1;
            end else if (phase == 2'd1) begin
              dio_lvl_next    = shift_byte[0];
              shift_byte_next = shift_byte >> 1;
              phase_next      = 2'd2;
            end else begin
              clk_lvl_next   = 1'b1;
              phase_next     = 2'd0;
              bit_count_next = bit_count + 4'd1;
            end
          end else begin
            // acknowledge clock, data released, never sampled
            case (phase)
              2'd0: clk_lvl_next = 1'b0;
              2'd1: drive_lvl_next = 1'b0;
              2'd2: clk_lvl_next = 1'b1;
              default: begin
                drive_lvl_next = 1'b1;
                done           = 1'b1;
              end
            endcase
            phase_next = phase + 2'd1;
          end
        end
        default: begin
          active_next    = 1'b0;
          phase_next     = '0;
          bit_count_next = '0;
        end
      endcase

      if (done) begin
        phase_next         = '0;
        bit_count_next     = '0;
        sequence_step_next = sequence_step + 4'd1;
        if (nxt_el.kind == EL_END) begin
          active_next = 1'b0;
        end
      end
    end

    result.clk_pin   = clk_lvl_next;
    result.dio_pin   = drive_lvl_next && dio_lvl_next;
    result.dio_drive = drive_lvl_next;
    result.busy_res  = active_next;
    result.rejected  = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= '0;
      shift_byte     <= '0;
      bit_count      <= '0;
      sequence_step  <= '0;
      active         <= 1'b0;
      latched_digits <= '0;
      latched_column <= '0;
      latched_func   <= FUNC_TICK;
      latched_bright <= '0;
      clk_lvl        <= 1'b0;
      dio_lvl        <= 1'b0;
      drive_lvl      <= 1'b1;
    end else if (in_accept) begin
      phase          <= phase_next;
      shift_byte     <= shift_byte_next;
      bit_count      <= bit_count_next;
      sequence_step  <= sequence_step_next;
      active         <= active_next;
      latched_digits <= latched_digits_next;
      latched_column <= latched_column_next;
      latched_func   <= latched_func_next;
      latched_bright <= latched_bright_next;
      clk_lvl        <= clk_lvl_next;
      dio_lvl        <= dio_lvl_next;
      drive_lvl      <= drive_lvl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_accept || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data <= result;
    end
  end

`ifndef SYNTH
  // a dropped command never ends the running sequence
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.rejected |-> out_data.busy_res)
    else $error("rejected beat reported while idle");

  // idle leaves the frame counters cleared
  assert property (@(posedge clk) disable iff (rst)
    !active |-> (phase == 2'd0 && bit_count == 4'd0))
    else $error("frame counters not cleared while idle");

  assert property (@(posedge clk) disable iff (rst)
    bit_count <= 4'd8)
    else $error("bit count ran past one byte");

  // a command taken while idle starts a sequence
  assert property (@(posedge clk) disable iff (rst)
    in_accept && in_data.func != FUNC_TICK && !active |=> active)
    else $error("accepted command did not start a sequence");
`endif

endmodule
